>>> sv/fcp_pkg.sv
// Shared types, codes and reply tables for the serial command parser.
// No dependencies; every other file refers to this package by scoped names.
package fcp_pkg;

   localparam int REPORT_CHANNELS = 16;
   localparam int MASK_W = 16;
   localparam logic [MASK_W-1:0] CHAN_MASK = MASK_W'((33'h1 << REPORT_CHANNELS) - 33'h1);
   localparam logic [MASK_W-1:0] ANALOG_RESET = 16'h0007 & CHAN_MASK;
   localparam logic [MASK_W-1:0] DIGITAL_RESET = 16'h0001 & CHAN_MASK;

   // job queue between parser and result side
   localparam int JOB_DEPTH = 4;
   localparam int JOB_PTR_W = $clog2(JOB_DEPTH);

   // status bytes, after the low nibble is dropped for bytes below 0xF0
   localparam logic [7:0] ST_SYSEX = 8'hF0;
   localparam logic [7:0] ST_DIGITAL = 8'h90;
   localparam logic [7:0] ST_ANALOG = 8'hE0;
   localparam logic [7:0] ST_PIN_MODE = 8'hF4;
   localparam logic [7:0] ST_REP_ANALOG = 8'hC0;
   localparam logic [7:0] ST_REP_DIGITAL = 8'hD0;
   localparam logic [7:0] ST_VERSION = 8'hF9;
   localparam logic [7:0] ST_EOX = 8'hF7;
   localparam logic [7:0] ST_HIGH_BITS = 8'hF0;

   // sysex command bytes
   localparam logic [7:0] SX_FIRMWARE = 8'h79;
   localparam logic [7:0] SX_MAPPING = 8'h69;
   localparam logic [7:0] SX_CAPABILITY = 8'h6B;
   localparam logic [7:0] SX_PIN_STATE = 8'h6D;
   localparam logic [7:0] SX_EXT_ANALOG = 8'h6F;

   localparam logic [7:0] VER_MAJOR = 8'h02;
   localparam logic [7:0] VER_MINOR = 8'h03;

   localparam int IDX_W = 5;
   localparam logic [IDX_W-1:0] VERSION_LAST = 5'd2;
   localparam logic [IDX_W-1:0] FIRMWARE_LAST = 5'd22;
   localparam logic [IDX_W-1:0] NAME_FIRST = 5'd4;
   localparam int NAME_LEN = 18;

   localparam logic [7:0] FW_NAME [NAME_LEN] = '{
      8'h46, 8'h00, 8'h49, 8'h00, 8'h52, 8'h00, 8'h4D, 8'h00, 8'h41, 8'h00,
      8'h54, 8'h00, 8'h41, 8'h00, 8'h2E, 8'h00, 8'h63, 8'h00
   };

   typedef enum logic [3:0] {
      PH_IDLE, PH_SYSEX_CMD, PH_EXT_PIN, PH_EXT_D1, PH_EXT_D2,
      PH_DIG_D1, PH_DIG_D2, PH_ANA_D1, PH_ANA_D2,
      PH_MODE_PIN, PH_MODE_VAL, PH_REP_ANA, PH_REP_DIG
   } phase_type;

   typedef enum logic [2:0] {
      ACT_TX, ACT_PORT, ACT_PWM, ACT_MODE, ACT_MAP, ACT_CAP, ACT_PSTATE
   } action_type;

   typedef enum logic [1:0] {
      JOB_CMD, JOB_VERSION, JOB_FIRMWARE
   } job_kind_type;

   // one decoded message handed from the parser to the result side
   typedef struct packed {
      job_kind_type kind;
      action_type action;
      logic [7:0] target;
      logic [7:0] value;
      logic [MASK_W-1:0] amask;
      logic [MASK_W-1:0] dmask;
   } job_type;

   function automatic logic [MASK_W-1:0] set_bit(input logic [MASK_W-1:0] m,
                                                 input logic [3:0] ch,
                                                 input logic on);
      logic [MASK_W-1:0] r;
      r = m;
      if (5'(ch) < 5'(REPORT_CHANNELS)) begin
         r[ch] = on;
         r = r & CHAN_MASK;
      end
      return r;
   endfunction

   function automatic logic [7:0] reply_byte(input job_kind_type kind,
                                             input logic [IDX_W-1:0] idx);
      logic [7:0] b;
      logic [IDX_W-1:0] n;
      b = 8'h00;
      n = idx - NAME_FIRST;
      if (kind == JOB_VERSION) begin
         case (idx)
            5'd0: b = ST_VERSION;
            5'd1: b = VER_MAJOR;
            default: b = VER_MINOR;
         endcase
      end else begin
         case (idx)
            5'd0: b = ST_SYSEX;
            5'd1: b = SX_FIRMWARE;
            5'd2: b = VER_MAJOR;
            5'd3: b = VER_MINOR;
            FIRMWARE_LAST: b = ST_EOX;
            default: b = (n < 5'(NAME_LEN)) ? FW_NAME[n] : 8'h00;
         endcase
      end
      return b;
   endfunction

   function automatic logic [IDX_W-1:0] job_last_idx(input job_kind_type kind);
      logic [IDX_W-1:0] r;
      case (kind)
         JOB_VERSION: r = VERSION_LAST;
         JOB_FIRMWARE: r = FIRMWARE_LAST;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

>>> sv/fcp_front.sv
// Byte parser: phase machine, held message bytes and report enable masks.
// Emits one job per completed non-report message. Depends on fcp_pkg.
module fcp_front (
   input  logic clock,
   input  logic reset,
   input  logic accept,
   input  logic [7:0] rx_byte,
   output logic job_push,
   output fcp_pkg::job_type job
);

   fcp_pkg::phase_type phase_ff, phase_in;
   logic [7:0] held_status_ff, held_status_in;
   logic [7:0] held_target_ff, held_target_in;
   logic [7:0] held_first_ff, held_first_in;
   logic [fcp_pkg::MASK_W-1:0] amask_ff, amask_in;
   logic [fcp_pkg::MASK_W-1:0] dmask_ff, dmask_in;
   logic [7:0] status;
   logic hi_bit;

   assign status = (rx_byte < fcp_pkg::ST_HIGH_BITS) ? (rx_byte & fcp_pkg::ST_HIGH_BITS)
                                                     : rx_byte;
   // extended analog: an end-of-sysex byte in the high data slot counts as zero
   assign hi_bit = (rx_byte == fcp_pkg::ST_EOX) ? 1'b0 : rx_byte[0];

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         case (phase_ff)
            fcp_pkg::PH_IDLE: begin
               case (status)
                  fcp_pkg::ST_SYSEX: phase_in = fcp_pkg::PH_SYSEX_CMD;
                  fcp_pkg::ST_DIGITAL: phase_in = fcp_pkg::PH_DIG_D1;
                  fcp_pkg::ST_ANALOG: phase_in = fcp_pkg::PH_ANA_D1;
                  fcp_pkg::ST_PIN_MODE: phase_in = fcp_pkg::PH_MODE_PIN;
                  fcp_pkg::ST_REP_ANALOG: phase_in = fcp_pkg::PH_REP_ANA;
                  fcp_pkg::ST_REP_DIGITAL: phase_in = fcp_pkg::PH_REP_DIG;
                  default: phase_in = fcp_pkg::PH_IDLE;
               endcase
            end
            fcp_pkg::PH_SYSEX_CMD: begin
               phase_in = (rx_byte == fcp_pkg::SX_EXT_ANALOG) ? fcp_pkg::PH_EXT_PIN
                                                              : fcp_pkg::PH_IDLE;
            end
            fcp_pkg::PH_EXT_PIN: phase_in = fcp_pkg::PH_EXT_D1;
            fcp_pkg::PH_EXT_D1: phase_in = fcp_pkg::PH_EXT_D2;
            fcp_pkg::PH_DIG_D1: phase_in = fcp_pkg::PH_DIG_D2;
            fcp_pkg::PH_ANA_D1: phase_in = fcp_pkg::PH_ANA_D2;
            fcp_pkg::PH_MODE_PIN: phase_in = fcp_pkg::PH_MODE_VAL;
            default: phase_in = fcp_pkg::PH_IDLE;
         endcase
      end
   end

   // held bytes, masks and job output
   always_comb begin
      held_status_in = held_status_ff;
      held_target_in = held_target_ff;
      held_first_in = held_first_ff;
      amask_in = amask_ff;
      dmask_in = dmask_ff;
      job_push = 1'b0;
      job.kind = fcp_pkg::JOB_CMD;
      job.action = fcp_pkg::ACT_TX;
      job.target = 8'h00;
      job.value = 8'h00;
      job.amask = amask_ff;
      job.dmask = dmask_ff;
      if (accept) begin
         case (phase_ff)
            fcp_pkg::PH_IDLE: begin
               held_status_in = rx_byte;
               case (status)
                  fcp_pkg::ST_VERSION: begin
                     job_push = 1'b1;
                     job.kind = fcp_pkg::JOB_VERSION;
                  end
                  fcp_pkg::ST_DIGITAL: held_target_in = {4'h0, rx_byte[3:0]};
                  fcp_pkg::ST_ANALOG: held_target_in = {4'h0, rx_byte[3:0]};
                  default: ;
               endcase
            end
            fcp_pkg::PH_SYSEX_CMD: begin
               case (rx_byte)
                  fcp_pkg::SX_FIRMWARE: begin
                     job_push = 1'b1;
                     job.kind = fcp_pkg::JOB_FIRMWARE;
                  end
                  fcp_pkg::SX_MAPPING: begin
                     job_push = 1'b1;
                     job.action = fcp_pkg::ACT_MAP;
                  end
                  fcp_pkg::SX_CAPABILITY: begin
                     job_push = 1'b1;
                     job.action = fcp_pkg::ACT_CAP;
                  end
                  fcp_pkg::SX_PIN_STATE: begin
                     job_push = 1'b1;
                     job.action = fcp_pkg::ACT_PSTATE;
                  end
                  default: ;
               endcase
            end
            fcp_pkg::PH_EXT_PIN: held_target_in = rx_byte;
            fcp_pkg::PH_EXT_D1: held_first_in = rx_byte;
            fcp_pkg::PH_EXT_D2: begin
               job_push = 1'b1;
               job.action = fcp_pkg::ACT_PWM;
               job.target = held_target_ff;
               job.value = {hi_bit, held_first_ff[6:0]};
            end
            fcp_pkg::PH_DIG_D1: held_first_in = rx_byte;
            fcp_pkg::PH_DIG_D2: begin
               job_push = 1'b1;
               job.action = fcp_pkg::ACT_PORT;
               job.target = held_target_ff;
               job.value = {rx_byte[0], held_first_ff[6:0]};
            end
            fcp_pkg::PH_ANA_D1: held_first_in = rx_byte;
            fcp_pkg::PH_ANA_D2: begin
               job_push = 1'b1;
               job.action = fcp_pkg::ACT_PWM;
               job.target = held_target_ff;
               job.value = {rx_byte[0], held_first_ff[6:0]};
            end
            fcp_pkg::PH_MODE_PIN: held_target_in = rx_byte;
            fcp_pkg::PH_MODE_VAL: begin
               job_push = 1'b1;
               job.action = fcp_pkg::ACT_MODE;
               job.target = held_target_ff;
               job.value = rx_byte;
            end
            fcp_pkg::PH_REP_ANA:
               amask_in = fcp_pkg::set_bit(amask_ff, held_status_ff[3:0], rx_byte != 8'h00);
            fcp_pkg::PH_REP_DIG:
               dmask_in = fcp_pkg::set_bit(dmask_ff, held_status_ff[3:0], rx_byte != 8'h00);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= fcp_pkg::PH_IDLE;
         held_status_ff <= 8'h00;
         held_target_ff <= 8'h00;
         held_first_ff <= 8'h00;
         amask_ff <= fcp_pkg::ANALOG_RESET;
         dmask_ff <= fcp_pkg::DIGITAL_RESET;
      end else begin
         phase_ff <= phase_in;
         held_status_ff <= held_status_in;
         held_target_ff <= held_target_in;
         held_first_ff <= held_first_in;
         amask_ff <= amask_in;
         dmask_ff <= dmask_in;
      end
   end

   a_push_needs_beat: assert property (@(posedge clock) disable iff (reset)
      job_push |-> accept)
      else $error("job pushed without an input beat");

   a_masks_in_range: assert property (@(posedge clock) disable iff (reset)
      ((amask_ff | dmask_ff) & ~fcp_pkg::CHAN_MASK) == '0)
      else $error("report mask bit set beyond channel count");

   a_report_no_job: assert property (@(posedge clock) disable iff (reset)
      (accept && (phase_ff == fcp_pkg::PH_REP_ANA || phase_ff == fcp_pkg::PH_REP_DIG))
      |-> !job_push)
      else $error("report message produced a job");

endmodule

>>> sv/fcp_job_queue.sv
// Short queue of decoded jobs between the parser and the result side.
// Register file with head and tail pointers. Depends on fcp_pkg.
module fcp_job_queue (
   input  logic clock,
   input  logic reset,
   input  logic push_in,
   input  fcp_pkg::job_type push_job,
   output logic full_out,
   input  logic pop_in,
   output logic head_valid,
   output fcp_pkg::job_type head_job
);

   fcp_pkg::job_type entries [fcp_pkg::JOB_DEPTH];
   logic [fcp_pkg::JOB_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [fcp_pkg::JOB_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [fcp_pkg::JOB_PTR_W:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full_out = (count_ff == (fcp_pkg::JOB_PTR_W+1)'(fcp_pkg::JOB_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job = entries[rd_ptr_ff];
   assign do_push = push_in && !full_out;
   assign do_pop = pop_in && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_in |-> !full_out)
      else $error("job pushed into a full queue");

   a_count_matches_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff <= (fcp_pkg::JOB_PTR_W+1)'(fcp_pkg::JOB_DEPTH)) &&
      ((fcp_pkg::JOB_PTR_W'(wr_ptr_ff - rd_ptr_ff)) ==
       count_ff[fcp_pkg::JOB_PTR_W-1:0]))
      else $error("queue count out of step with pointers");

endmodule

>>> sv/fcp_back.sv
// Result side: expands each job into result beats and holds them in the
// output register until popped. Depends on fcp_pkg.
module fcp_back (
   input  logic clock,
   input  logic reset,
   input  logic head_valid,
   input  fcp_pkg::job_type head_job,
   output logic head_pop,
   input  logic pop,
   output logic empty,
   output logic [2:0] rsp_action,
   output logic [7:0] rsp_target,
   output logic [7:0] rsp_value,
   output logic [7:0] rsp_tx_byte,
   output logic rsp_last,
   output logic [15:0] rsp_analog_report_mask,
   output logic [15:0] rsp_digital_report_mask
);

   logic [fcp_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic valid_ff, valid_in;
   logic advance, beat_last, is_cmd;
   fcp_pkg::action_type action_ff, action_in;
   logic [7:0] target_ff, target_in;
   logic [7:0] value_ff, value_in;
   logic [7:0] tx_ff, tx_in;
   logic last_ff, last_in;
   logic [15:0] amask_ff, amask_in;
   logic [15:0] dmask_ff, dmask_in;

   assign is_cmd = (head_job.kind == fcp_pkg::JOB_CMD);
   assign beat_last = (idx_ff == fcp_pkg::job_last_idx(head_job.kind));
   // load a fresh beat when the output register is free or being drained
   assign advance = head_valid && (!valid_ff || pop);
   assign head_pop = advance && beat_last;

   always_comb begin
      valid_in = valid_ff;
      if (advance) begin
         valid_in = 1'b1;
      end else if (pop) begin
         valid_in = 1'b0;
      end
      idx_in = idx_ff;
      if (advance) begin
         idx_in = beat_last ? '0 : idx_ff + 1'b1;
      end
      action_in = is_cmd ? head_job.action : fcp_pkg::ACT_TX;
      target_in = is_cmd ? head_job.target : 8'h00;
      value_in = is_cmd ? head_job.value : 8'h00;
      tx_in = is_cmd ? 8'h00 : fcp_pkg::reply_byte(head_job.kind, idx_ff);
      last_in = beat_last;
      amask_in = head_job.amask;
      dmask_in = head_job.dmask;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         action_ff <= action_in;
         target_ff <= target_in;
         value_ff <= value_in;
         tx_ff <= tx_in;
         last_ff <= last_in;
         amask_ff <= amask_in;
         dmask_ff <= dmask_in;
      end
   end

   assign empty = !valid_ff;
   assign rsp_action = 3'(action_ff);
   assign rsp_target = target_ff;
   assign rsp_value = value_ff;
   assign rsp_tx_byte = tx_ff;
   assign rsp_last = last_ff;
   assign rsp_analog_report_mask = amask_ff;
   assign rsp_digital_report_mask = dmask_ff;

   a_burst_has_job: assert property (@(posedge clock) disable iff (reset)
      (idx_ff != '0) |-> (head_valid && !is_cmd))
      else $error("burst index running without a burst job");

   a_idx_bounded: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= fcp_pkg::FIRMWARE_LAST)
      else $error("burst index past longest reply");

   a_pop_on_last: assert property (@(posedge clock) disable iff (reset)
      head_pop |=> (valid_ff && last_ff))
      else $error("job retired without a last beat");

endmodule

>>> sv/firmata_command_parser.sv
// Top level of the serial command parser: byte parser, job queue and
// result expander. Depends on fcp_pkg, fcp_front, fcp_job_queue, fcp_back.
//
//  channel   | handshake          | payload
//  ----------+--------------------+-----------------------------------------
//  request   | push / full        | req_rx_byte
//  response  | pop / empty        | rsp_action, rsp_target, rsp_value,
//            |                    | rsp_tx_byte, rsp_last, rsp_*_report_mask
//
// A completed non-report message becomes one job in a four-entry queue; its
// first result beat enters the expander's output register once it is free
// or being popped. Single-result commands retire at one beat a cycle while
// popped; the version reply is 3 beats and the firmware reply 23 at the same
// rate, set by the expander's beat counter. full rises only when four jobs
// are queued, so bytes keep flowing while a burst drains. Reset is
// synchronous and returns the parser to waiting for a status byte, with
// analog reporting on channels 0 to 2 and digital reporting on port 0.
module firmata_command_parser (
   input  logic clock,
   input  logic reset,
   input  logic push,
   output logic full,
   input  logic [7:0] req_rx_byte,
   output logic empty,
   input  logic pop,
   output logic [2:0] rsp_action,
   output logic [7:0] rsp_target,
   output logic [7:0] rsp_value,
   output logic [7:0] rsp_tx_byte,
   output logic rsp_last,
   output logic [15:0] rsp_analog_report_mask,
   output logic [15:0] rsp_digital_report_mask
);

   logic accept;
   logic job_push;
   fcp_pkg::job_type new_job;
   logic head_valid, head_pop;
   fcp_pkg::job_type head_job;

   // a byte is taken whenever there is room for whatever job it may finish
   assign accept = push && !full;

   fcp_front u_front (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .rx_byte(req_rx_byte),
      .job_push(job_push),
      .job(new_job)
   );

   fcp_job_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push_in(job_push),
      .push_job(new_job),
      .full_out(full),
      .pop_in(head_pop),
      .head_valid(head_valid),
      .head_job(head_job)
   );

   fcp_back u_back (
      .clock(clock),
      .reset(reset),
      .head_valid(head_valid),
      .head_job(head_job),
      .head_pop(head_pop),
      .pop(pop),
      .empty(empty),
      .rsp_action(rsp_action),
      .rsp_target(rsp_target),
      .rsp_value(rsp_value),
      .rsp_tx_byte(rsp_tx_byte),
      .rsp_last(rsp_last),
      .rsp_analog_report_mask(rsp_analog_report_mask),
      .rsp_digital_report_mask(rsp_digital_report_mask)
   );

endmodule

>>> tb/sv/firmata_command_parser_test.sv
// Self-checking bench for firmata_command_parser: directed table, then random messages.
// Depends on fcp_pkg (codes, enums) and the parser RTL; nothing else is read.
module firmata_command_parser_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RESET_CYCLES = 12;
   localparam int RANDOM_ITEMS = 355;  // random bytes, on top of the directed table
   localparam int IDLE_PCT = 27;
   localparam int HOLD_CYCLES = 150;   // receiver hold-off to fill the job queue
   localparam int DRAIN_CYCLES = 50;   // quiet time after the last beat
   localparam int CYCLE_LIMIT = 200000;

   // one byte offered to the parser; typed rows carry the single beat they must cause
   typedef struct packed {
      logic [7:0] rx;
      logic typed;
      fcp_pkg::action_type action;
      logic [7:0] target;
      logic [7:0] value;
      logic [7:0] tx;
   } stim_type;

   // one result beat as the parser should present it
   typedef struct packed {
      fcp_pkg::action_type action;
      logic [7:0] target;
      logic [7:0] value;
      logic [7:0] tx;
      logic last;
      logic [15:0] amask;
      logic [15:0] dmask;
   } beat_type;

   // reply text of the firmware query, one character then a zero byte each
   localparam logic [7:0] NAME_CHARS [9] = '{
      8'h46, 8'h49, 8'h52, 8'h4D, 8'h41, 8'h54, 8'h41, 8'h2E, 8'h63
   };

   // Directed table. Expected beats are typed in only for the obvious single-beat rows;
   // the rest fall through to the decoder model below.
   localparam int DIRECTED_LEN = 27;
   localparam stim_type DIRECTED [DIRECTED_LEN] = '{
      // unknown status bytes in the waiting phase are dropped
      '{8'hFF, 1'b0, fcp_pkg::ACT_TX, 8'h00, 8'h00, 8'h00},
      '{fcp_pkg::ST_EOX, 1'b0, fcp_pkg::ACT_TX, 8'h00, 8'h00, 8'h00},
      // digital message, top port, all value bits set
      '{fcp_pkg::ST_DIGITAL | 8'h0F, 1'b0, fcp_pkg::ACT_TX, 8'h00, 8'h00, 8'h00},
      '{8'h7F, 1'b0, fcp_pkg::ACT_TX, 8'h00, 8'h00, 8'h00},
      '{8'h01, 1'b1, fcp_pkg::ACT_PORT, 8'h0F, 8'hFF, 8'h00},
      // analog message, port 0, only the ignored data bits set
      '{fcp_pkg::ST_ANALOG, 1'b0, fcp_pkg::ACT_TX, 8'h00, 8'h00, 8'h00},
      '{8'h80, 1'b0, fcp_pkg::ACT_TX, 8'h00, 8'h00, 8'h00},
      '{8'hFE, 1'b1, fcp_pkg::ACT_PWM, 8'h00, 8'h00, 8'h00},
      // pin mode with a status byte sitting in the pin position: no resync
      '{fcp_pkg::ST_PIN_MODE, 1'b0, fcp_pkg::ACT_TX, 8'h00, 8'h00, 8'h00},
      '{fcp_pkg::ST_SYSEX, 1'b0, fcp_pkg::ACT_TX, 8'h00, 8'h00, 8'h00},
      '{8'h00, 1'b1, fcp_pkg::ACT_MODE, fcp_pkg::ST_SYSEX, 8'h00, 8'h00},
      // enable analog channel 15, disable digital port 0
      '{fcp_pkg::ST_REP_ANALOG | 8'h0F, 1'b0, fcp_pkg::ACT_TX, 8'h00, 8'h00, 8'h00},
      '{8'h01, 1'b0, fcp_pkg::ACT_TX, 8'h00, 8'h00, 8'h00},
      '{fcp_pkg::ST_REP_DIGITAL, 1'b0, fcp_pkg::ACT_TX, 8'h00, 8'h00, 8'h00},
      '{8'h00, 1'b0, fcp_pkg::ACT_TX, 8'h00, 8'h00, 8'h00},
      // version reply, then the full firmware reply
      '{fcp_pkg::ST_VERSION, 1'b0, fcp_pkg::ACT_TX, 8'h00, 8'h00, 8'h00},
      '{fcp_pkg::ST_SYSEX, 1'b0, fcp_pkg::ACT_TX, 8'h00, 8'h00, 8'h00},
      '{fcp_pkg::SX_FIRMWARE, 1'b0, fcp_pkg::ACT_TX, 8'h00, 8'h00, 8'h00},
      // capability query
      '{fcp_pkg::ST_SYSEX, 1'b0, fcp_pkg::ACT_TX, 8'h00, 8'h00, 8'h00},
      '{fcp_pkg::SX_CAPABILITY, 1'b1, fcp_pkg::ACT_CAP, 8'h00, 8'h00, 8'h00},
      // extended analog with end-of-sysex as the high byte, read as zero
      '{fcp_pkg::ST_SYSEX, 1'b0, fcp_pkg::ACT_TX, 8'h00, 8'h00, 8'h00},
      '{fcp_pkg::SX_EXT_ANALOG, 1'b0, fcp_pkg::ACT_TX, 8'h00, 8'h00, 8'h00},
      '{8'h07, 1'b0, fcp_pkg::ACT_TX, 8'h00, 8'h00, 8'h00},
      '{8'h05, 1'b0, fcp_pkg::ACT_TX, 8'h00, 8'h00, 8'h00},
      '{fcp_pkg::ST_EOX, 1'b1, fcp_pkg::ACT_PWM, 8'h07, 8'h05, 8'h00},
      // unknown sysex command: nothing comes out
      '{fcp_pkg::ST_SYSEX, 1'b0, fcp_pkg::ACT_TX, 8'h00, 8'h00, 8'h00},
      '{8'h00, 1'b0, fcp_pkg::ACT_TX, 8'h00, 8'h00, 8'h00}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic pop = 1'b0;
   logic [7:0] req_rx_byte = 8'h00;
   logic full;
   logic empty;
   logic [2:0] rsp_action;
   logic [7:0] rsp_target;
   logic [7:0] rsp_value;
   logic [7:0] rsp_tx_byte;
   logic rsp_last;
   logic [15:0] rsp_analog_report_mask;
   logic [15:0] rsp_digital_report_mask;

   // decoder model state, starting from the post-reset values
   fcp_pkg::phase_type phase = fcp_pkg::PH_IDLE;
   logic [7:0] held_status = 8'h00;
   logic [7:0] held_target = 8'h00;
   logic [7:0] held_first = 8'h00;
   logic [15:0] analog_en = 16'h0007;
   logic [15:0] digital_en = 16'h0001;

   stim_type rx_queue [$];
   stim_type cur_byte;
   beat_type burst [$];          // beats caused by the byte just decoded
   beat_type pending_beats [$];  // beats still owed by the parser
   bit offering = 1'b0;          // cur_byte is on the bus and not yet taken
   bit driving_on = 1'b0;
   bit hold_rsp = 1'b0;
   int accepted_bytes = 0;
   int beat_count = 0;
   int queued_items = 0;
   int errors = 0;
   int cycle_count = 0;

   firmata_command_parser u_top (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_rx_byte(req_rx_byte),
      .empty(empty),
      .pop(pop),
      .rsp_action(rsp_action),
      .rsp_target(rsp_target),
      .rsp_value(rsp_value),
      .rsp_tx_byte(rsp_tx_byte),
      .rsp_last(rsp_last),
      .rsp_analog_report_mask(rsp_analog_report_mask),
      .rsp_digital_report_mask(rsp_digital_report_mask)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      errors++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want)
         report_mismatch($sformatf("beat %0d %s = %h, want %h", beat_count, name, got, want));
   endtask

   // data bytes carry 7 bits; the eighth comes from bit 0 of the following byte
   function automatic logic [7:0] join_data(input logic [7:0] lo, input logic [7:0] hi);
      return {hi[0], lo[6:0]};
   endfunction

   function automatic logic [15:0] set_enable(input logic [15:0] m, input logic [3:0] ch,
                                             input logic on);
      logic [15:0] r;
      logic [15:0] chan_bits;
      r = m;
      chan_bits = 16'((32'h1 << fcp_pkg::REPORT_CHANNELS) - 32'h1);
      if (int'(ch) < fcp_pkg::REPORT_CHANNELS) begin
         r[ch] = on;
         r = r & chan_bits;
      end
      return r;
   endfunction

   function automatic void add_beat(input fcp_pkg::action_type act, input logic [7:0] tgt,
                                    input logic [7:0] val, input logic [7:0] tx);
      beat_type b;
      b = '{act, tgt, val, tx, 1'b0, 16'h0000, 16'h0000};
      burst.push_back(b);
   endfunction

   // Decoder model: advances the phase machine by one byte and leaves its beats in burst.
   task automatic decode_byte(input logic [7:0] b);
      logic [7:0] s;
      logic [7:0] hi;
      s = (b < fcp_pkg::ST_HIGH_BITS) ? (b & fcp_pkg::ST_HIGH_BITS) : b;
      burst.delete();
      case (phase)
         fcp_pkg::PH_IDLE: begin
            held_status = b;
            case (s)
               fcp_pkg::ST_SYSEX: phase = fcp_pkg::PH_SYSEX_CMD;
               fcp_pkg::ST_VERSION: begin
                  add_beat(fcp_pkg::ACT_TX, 8'h00, 8'h00, fcp_pkg::ST_VERSION);
                  add_beat(fcp_pkg::ACT_TX, 8'h00, 8'h00, fcp_pkg::VER_MAJOR);
                  add_beat(fcp_pkg::ACT_TX, 8'h00, 8'h00, fcp_pkg::VER_MINOR);
               end
               fcp_pkg::ST_DIGITAL: begin
                  held_target = {4'h0, b[3:0]};
                  phase = fcp_pkg::PH_DIG_D1;
               end
               fcp_pkg::ST_ANALOG: begin
                  held_target = {4'h0, b[3:0]};
                  phase = fcp_pkg::PH_ANA_D1;
               end
               fcp_pkg::ST_PIN_MODE: phase = fcp_pkg::PH_MODE_PIN;
               fcp_pkg::ST_REP_ANALOG: phase = fcp_pkg::PH_REP_ANA;
               fcp_pkg::ST_REP_DIGITAL: phase = fcp_pkg::PH_REP_DIG;
               default: ;
            endcase
         end
         fcp_pkg::PH_SYSEX_CMD: begin
            phase = fcp_pkg::PH_IDLE;
            if (b == fcp_pkg::SX_FIRMWARE) begin
               add_beat(fcp_pkg::ACT_TX, 8'h00, 8'h00, fcp_pkg::ST_SYSEX);
               add_beat(fcp_pkg::ACT_TX, 8'h00, 8'h00, fcp_pkg::SX_FIRMWARE);
               add_beat(fcp_pkg::ACT_TX, 8'h00, 8'h00, fcp_pkg::VER_MAJOR);
               add_beat(fcp_pkg::ACT_TX, 8'h00, 8'h00, fcp_pkg::VER_MINOR);
               foreach (NAME_CHARS[i]) begin
                  add_beat(fcp_pkg::ACT_TX, 8'h00, 8'h00, NAME_CHARS[i]);
                  add_beat(fcp_pkg::ACT_TX, 8'h00, 8'h00, 8'h00);
               end
               add_beat(fcp_pkg::ACT_TX, 8'h00, 8'h00, fcp_pkg::ST_EOX);
            end else if (b == fcp_pkg::SX_MAPPING) begin
               add_beat(fcp_pkg::ACT_MAP, 8'h00, 8'h00, 8'h00);
            end else if (b == fcp_pkg::SX_CAPABILITY) begin
               add_beat(fcp_pkg::ACT_CAP, 8'h00, 8'h00, 8'h00);
            end else if (b == fcp_pkg::SX_PIN_STATE) begin
               add_beat(fcp_pkg::ACT_PSTATE, 8'h00, 8'h00, 8'h00);
            end else if (b == fcp_pkg::SX_EXT_ANALOG) begin
               phase = fcp_pkg::PH_EXT_PIN;
            end
         end
         fcp_pkg::PH_EXT_PIN: begin
            held_target = b;
            phase = fcp_pkg::PH_EXT_D1;
         end
         fcp_pkg::PH_EXT_D1: begin
            held_first = b;
            phase = fcp_pkg::PH_EXT_D2;
         end
         fcp_pkg::PH_EXT_D2: begin
            hi = (b == fcp_pkg::ST_EOX) ? 8'h00 : b;
            add_beat(fcp_pkg::ACT_PWM, held_target, join_data(held_first, hi), 8'h00);
            phase = fcp_pkg::PH_IDLE;
         end
         fcp_pkg::PH_DIG_D1: begin
            held_first = b;
            phase = fcp_pkg::PH_DIG_D2;
         end
         fcp_pkg::PH_DIG_D2: begin
            add_beat(fcp_pkg::ACT_PORT, held_target, join_data(held_first, b), 8'h00);
            phase = fcp_pkg::PH_IDLE;
         end
         fcp_pkg::PH_ANA_D1: begin
            held_first = b;
            phase = fcp_pkg::PH_ANA_D2;
         end
         fcp_pkg::PH_ANA_D2: begin
            add_beat(fcp_pkg::ACT_PWM, held_target, join_data(held_first, b), 8'h00);
            phase = fcp_pkg::PH_IDLE;
         end
         fcp_pkg::PH_MODE_PIN: begin
            held_target = b;
            phase = fcp_pkg::PH_MODE_VAL;
         end
         fcp_pkg::PH_MODE_VAL: begin
            add_beat(fcp_pkg::ACT_MODE, held_target, b, 8'h00);
            phase = fcp_pkg::PH_IDLE;
         end
         fcp_pkg::PH_REP_ANA: begin
            analog_en = set_enable(analog_en, held_status[3:0], b != 8'h00);
            phase = fcp_pkg::PH_IDLE;
         end
         fcp_pkg::PH_REP_DIG: begin
            digital_en = set_enable(digital_en, held_status[3:0], b != 8'h00);
            phase = fcp_pkg::PH_IDLE;
         end
         default: phase = fcp_pkg::PH_IDLE;
      endcase
      // every beat shows the enables as they stand after this byte
      foreach (burst[i]) begin
         burst[i].last = (i == burst.size() - 1);
         burst[i].amask = analog_en;
         burst[i].dmask = digital_en;
      end
   endtask

   task automatic queue_byte(input logic [7:0] b);
      stim_type s;
      s = '{b, 1'b0, fcp_pkg::ACT_TX, 8'h00, 8'h00, 8'h00};
      rx_queue.push_back(s);
      queued_items++;
   endtask

   // One random message: mostly well-formed with random content, some broken or noise.
   task automatic add_message();
      int pick;
      logic [7:0] cmd;
      pick = $urandom_range(0, 99);
      if (pick < 14) begin
         queue_byte(fcp_pkg::ST_DIGITAL | 8'($urandom_range(0, 15)));
         queue_byte(8'($urandom));
         queue_byte(8'($urandom));
      end else if (pick < 28) begin
         queue_byte(fcp_pkg::ST_ANALOG | 8'($urandom_range(0, 15)));
         queue_byte(8'($urandom));
         queue_byte(8'($urandom));
      end else if (pick < 38) begin
         queue_byte(fcp_pkg::ST_PIN_MODE);
         queue_byte(8'($urandom));
         queue_byte(8'($urandom));
      end else if (pick < 54) begin
         cmd = (pick < 46) ? fcp_pkg::ST_REP_ANALOG : fcp_pkg::ST_REP_DIGITAL;
         queue_byte(cmd | 8'($urandom_range(0, 15)));
         queue_byte(($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom));
      end else if (pick < 60) begin
         queue_byte(fcp_pkg::ST_VERSION);
      end else if (pick < 63) begin
         queue_byte(fcp_pkg::ST_SYSEX);
         queue_byte(fcp_pkg::SX_FIRMWARE);
      end else if (pick < 72) begin
         case ($urandom_range(0, 2))
            0: cmd = fcp_pkg::SX_MAPPING;
            1: cmd = fcp_pkg::SX_CAPABILITY;
            default: cmd = fcp_pkg::SX_PIN_STATE;
         endcase
         queue_byte(fcp_pkg::ST_SYSEX);
         queue_byte(cmd);
      end else if (pick < 82) begin
         queue_byte(fcp_pkg::ST_SYSEX);
         queue_byte(fcp_pkg::SX_EXT_ANALOG);
         queue_byte(8'($urandom));
         queue_byte(8'($urandom));
         queue_byte(($urandom_range(0, 3) == 0) ? fcp_pkg::ST_EOX : 8'($urandom));
      end else if (pick < 86) begin
         // sysex with an arbitrary command byte, usually unknown
         queue_byte(fcp_pkg::ST_SYSEX);
         queue_byte(8'($urandom));
      end else if (pick < 93) begin
         // truncated message: the next message's status lands in a data slot
         case ($urandom_range(0, 3))
            0: cmd = fcp_pkg::ST_DIGITAL | 8'($urandom_range(0, 15));
            1: cmd = fcp_pkg::ST_ANALOG | 8'($urandom_range(0, 15));
            2: cmd = fcp_pkg::ST_PIN_MODE;
            default: cmd = fcp_pkg::ST_SYSEX;
         endcase
         queue_byte(cmd);
      end else begin
         // noise in the waiting phase, mostly ignored
         queue_byte(8'($urandom));
      end
   endtask

   function automatic int idle_chance();
      // a stretch with no idling on either side
      return (accepted_bytes >= 120 && accepted_bytes < 200) ? 0 : IDLE_PCT;
   endfunction

   // Drive side: everything changes at the falling edge.
   always @(negedge clock) begin
      if (!offering && driving_on && rx_queue.size() != 0 &&
          $urandom_range(0, 99) >= idle_chance()) begin
         cur_byte = rx_queue.pop_front();
         req_rx_byte <= cur_byte.rx;
         push <= 1'b1;
         offering = 1'b1;
      end else if (!offering) begin
         push <= 1'b0;
      end
      pop <= driving_on && !hold_rsp && ($urandom_range(0, 99) >= idle_chance());
   end

   // Sample side: beats checked and bytes taken at the rising edge.
   always @(posedge clock) begin
      beat_type want;
      cycle_count++;
      if (pop && !empty) begin
         if (pending_beats.size() == 0) begin
            report_mismatch($sformatf("beat %0d with nothing owed, action %0d tx %h",
                                      beat_count, rsp_action, rsp_tx_byte));
         end else begin
            want = pending_beats.pop_front();
            check_field("action", 16'(rsp_action), 16'(want.action));
            check_field("target", 16'(rsp_target), 16'(want.target));
            check_field("value", 16'(rsp_value), 16'(want.value));
            check_field("tx_byte", 16'(rsp_tx_byte), 16'(want.tx));
            check_field("last", 16'(rsp_last), 16'(want.last));
            check_field("analog_mask", rsp_analog_report_mask, want.amask);
            check_field("digital_mask", rsp_digital_report_mask, want.dmask);
         end
         beat_count++;
      end
      if (push && !full) begin
         decode_byte(cur_byte.rx);
         if (cur_byte.typed) begin
            // typed rows replace the model's fields; masks still come from the model
            if (burst.size() != 1) begin
               report_mismatch($sformatf("byte %h: table row wants one beat, model gives %0d",
                                         cur_byte.rx, burst.size()));
            end else begin
               burst[0].action = cur_byte.action;
               burst[0].target = cur_byte.target;
               burst[0].value = cur_byte.value;
               burst[0].tx = cur_byte.tx;
            end
         end
         foreach (burst[i]) pending_beats.push_back(burst[i]);
         offering = 1'b0;
         accepted_bytes++;
      end
   end

   // Receiver hold-off: the sender keeps offering, the job queue fills and full rises.
   initial begin
      wait (accepted_bytes >= 240);
      @(posedge clock);
      hold_rsp = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp = 1'b0;
   end

   // Watchdog on the cycle counter.
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (DIRECTED[i]) rx_queue.push_back(DIRECTED[i]);
      while (queued_items < RANDOM_ITEMS) add_message();
      driving_on = 1'b1;
      // all bytes taken, then all owed beats drained, then a quiet spell
      while (rx_queue.size() != 0 || offering) @(posedge clock);
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
